FILE: design/jnp_pkg.sv
// Shared types and constants for the JSON number token parser.
`default_nettype none

package jnp_pkg;

   localparam int MANT_BITS     = 63;
   localparam int FRAC_OUT_BITS = 8;
   localparam int EXP_OUT_BITS  = 16;

   localparam logic [7:0] CHAR_MINUS   = 8'h2D;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_DOT     = 8'h2E;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_EXP_LO  = 8'h65;
   localparam logic [7:0] CHAR_EXP_UP  = 8'h45;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_MISSING   = 2'd1;
   localparam logic [1:0] STATUS_SATURATED = 2'd2;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       starts_number;
      logic       end_of_text;
   } req_item_type;

   typedef struct packed {
      logic                     is_integer;
      logic                     negative;
      logic [MANT_BITS-1:0]     mantissa;
      logic [FRAC_OUT_BITS-1:0] fraction_digits;
      logic                     exponent_negative;
      logic [EXP_OUT_BITS-1:0]  exponent_value;
      logic [1:0]               status;
      logic                     byte_consumed;
   } rsp_item_type;

endpackage

`default_nettype wire

FILE: design/jnp_channels.sv
// Valid/ready channel interfaces for text bytes in and number tokens out.
`default_nettype none

interface jnp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       starts_number;
   logic       end_of_text;

   modport source (output valid, output text_byte, output starts_number,
                   output end_of_text, input ready);
   modport sink   (input valid, input text_byte, input starts_number,
                   input end_of_text, output ready);
endinterface

interface jnp_rsp_if;
   logic                              valid;
   logic                              ready;
   logic                              is_integer;
   logic                              negative;
   logic [jnp_pkg::MANT_BITS-1:0]     mantissa;
   logic [jnp_pkg::FRAC_OUT_BITS-1:0] fraction_digits;
   logic                              exponent_negative;
   logic [jnp_pkg::EXP_OUT_BITS-1:0]  exponent_value;
   logic [1:0]                        status;
   logic                              byte_consumed;

   modport source (output valid, output is_integer, output negative, output mantissa,
                   output fraction_digits, output exponent_negative,
                   output exponent_value, output status, output byte_consumed,
                   input ready);
   modport sink   (input valid, input is_integer, input negative, input mantissa,
                   input fraction_digits, input exponent_negative,
                   input exponent_value, input status, input byte_consumed,
                   output ready);
endinterface

`default_nettype wire

FILE: design/jnp_in_stage.sv
// Input register that holds one text byte item ahead of the scanner.
`default_nettype none

module jnp_in_stage (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        in_valid,
   input  wire jnp_pkg::req_item_type in_item,
   output logic                       in_ready,
   input  wire                        advance,
   output logic                       held_valid,
   output jnp_pkg::req_item_type      held_item
);

   logic                  valid_ff, valid_in;
   jnp_pkg::req_item_type item_ff;

   // take a new item when empty or when the held one moves on this cycle
   assign in_ready = !valid_ff || advance;
   assign valid_in = (in_valid && in_ready) || (valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_valid && in_ready) begin
         item_ff <= in_item;
      end
   end

   assign held_valid = valid_ff;
   assign held_item  = item_ff;

endmodule

`default_nettype wire

FILE: design/jnp_scanner.sv
// Number grammar state machine with digit accumulation and result formatting.
`default_nettype none

module jnp_scanner #(
   parameter int EXP_BITS        = 16,
   parameter int FRAC_COUNT_BITS = 8
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        advance,
   input  wire jnp_pkg::req_item_type item,
   output logic                       emit,
   output jnp_pkg::rsp_item_type      result
);

   localparam int MB = jnp_pkg::MANT_BITS;
   localparam int FO = jnp_pkg::FRAC_OUT_BITS;
   localparam int EO = jnp_pkg::EXP_OUT_BITS;
   localparam int FW = (FRAC_COUNT_BITS > FO) ? FRAC_COUNT_BITS : FO;
   localparam int EW = (EXP_BITS > EO) ? EXP_BITS : EO;

   typedef enum logic [3:0] {
      PH_IDLE, PH_SIGN, PH_INT, PH_ZERO, PH_DOT, PH_FRAC, PH_EXP, PH_EXPSIGN, PH_EXPDIG
   } phase_type;

   phase_type                  phase_ff, phase_in;
   logic                       sign_ff, sign_in;
   logic [MB-1:0]              acc_ff, acc_in;
   logic                       intonly_ff, intonly_in;
   logic [FRAC_COUNT_BITS-1:0] frac_ff, frac_in;
   logic                       esign_ff, esign_in;
   logic [EXP_BITS-1:0]        eacc_ff, eacc_in;
   logic                       sat_ff, sat_in;

   logic [7:0]          c;
   logic                digit_hit;
   logic [3:0]          d;
   logic [MB+3:0]       mant_sum;
   logic                mant_full;
   logic [MB-1:0]       mant_next;
   logic [EXP_BITS+3:0] exp_sum;
   logic                exp_full;
   logic [EXP_BITS-1:0] exp_next;

   assign c         = item.text_byte;
   assign digit_hit = (c >= jnp_pkg::CHAR_ZERO) && (c <= jnp_pkg::CHAR_NINE);
   assign d         = 4'(c - jnp_pkg::CHAR_ZERO);

   // acc * 10 + d as two shifted adds; any carry above the field is overflow
   assign mant_sum  = ({4'd0, acc_ff} << 3) + ({4'd0, acc_ff} << 1) + (MB + 4)'(d);
   assign mant_full = |mant_sum[MB+3:MB];
   assign mant_next = mant_full ? {MB{1'b1}} : mant_sum[MB-1:0];

   assign exp_sum   = ({4'd0, eacc_ff} << 3) + ({4'd0, eacc_ff} << 1) + (EXP_BITS + 4)'(d);
   assign exp_full  = |exp_sum[EXP_BITS+3:EXP_BITS];
   assign exp_next  = exp_full ? {EXP_BITS{1'b1}} : exp_sum[EXP_BITS-1:0];

   phase_type cur;
   logic      reached;
   logic      err;
   logic      consumed;
   logic      is_exp_char;
   logic [FW-1:0] frac_wide;
   logic          frac_over;
   logic [EW-1:0] exp_wide;
   logic          exp_over;

   assign is_exp_char = (c == jnp_pkg::CHAR_EXP_LO) || (c == jnp_pkg::CHAR_EXP_UP);

   always_comb begin
      phase_in   = phase_ff;
      sign_in    = sign_ff;
      acc_in     = acc_ff;
      intonly_in = intonly_ff;
      frac_in    = frac_ff;
      esign_in   = esign_ff;
      eacc_in    = eacc_ff;
      sat_in     = sat_ff;
      emit       = 1'b0;
      err        = 1'b0;
      consumed   = 1'b0;
      reached    = 1'b0;
      cur        = phase_ff;
      if (advance) begin
         if (item.starts_number) begin
            sign_in    = 1'b0;
            acc_in     = '0;
            intonly_in = 1'b1;
            frac_in    = '0;
            esign_in   = 1'b0;
            eacc_in    = '0;
            sat_in     = 1'b0;
         end
         if (item.starts_number && c == jnp_pkg::CHAR_MINUS) begin
            sign_in  = 1'b1;
            phase_in = PH_SIGN;
            reached  = 1'b1;
         end else if (item.starts_number || phase_ff != PH_IDLE) begin
            cur     = item.starts_number ? PH_SIGN : phase_ff;
            reached = 1'b1;
            case (cur)
               PH_SIGN: begin
                  if (c == jnp_pkg::CHAR_ZERO) begin
                     phase_in = PH_ZERO;
                  end else if (digit_hit) begin
                     acc_in   = MB'(d);
                     phase_in = PH_INT;
                  end else begin
                     emit    = 1'b1;
                     err     = 1'b1;
                     reached = 1'b0;
                  end
               end
               PH_INT, PH_ZERO: begin
                  if (cur == PH_INT && digit_hit) begin
                     acc_in = mant_next;
                     if (mant_full) sat_in = 1'b1;
                  end else if (c == jnp_pkg::CHAR_DOT) begin
                     intonly_in = 1'b0;
                     phase_in   = PH_DOT;
                  end else if (is_exp_char) begin
                     intonly_in = 1'b0;
                     phase_in   = PH_EXP;
                  end else begin
                     emit    = 1'b1;
                     reached = 1'b0;
                  end
               end
               PH_DOT, PH_FRAC: begin
                  if (digit_hit) begin
                     acc_in = mant_next;
                     if (mant_full) sat_in = 1'b1;
                     if (&frac_ff) begin
                        sat_in = 1'b1;
                     end else begin
                        frac_in = frac_ff + FRAC_COUNT_BITS'(1);
                     end
                     phase_in = PH_FRAC;
                  end else if (cur == PH_DOT) begin
                     emit    = 1'b1;
                     err     = 1'b1;
                     reached = 1'b0;
                  end else if (is_exp_char) begin
                     phase_in = PH_EXP;
                  end else begin
                     emit    = 1'b1;
                     reached = 1'b0;
                  end
               end
               PH_EXP, PH_EXPSIGN, PH_EXPDIG: begin
                  if (cur == PH_EXP && c == jnp_pkg::CHAR_PLUS) begin
                     phase_in = PH_EXPSIGN;
                  end else if (cur == PH_EXP && c == jnp_pkg::CHAR_MINUS) begin
                     esign_in = 1'b1;
                     phase_in = PH_EXPSIGN;
                  end else if (digit_hit) begin
                     eacc_in = exp_next;
                     if (exp_full) sat_in = 1'b1;
                     phase_in = PH_EXPDIG;
                  end else begin
                     emit    = 1'b1;
                     err     = (cur != PH_EXPDIG);
                     reached = 1'b0;
                  end
               end
               default: begin
                  phase_in = PH_IDLE;
                  reached  = 1'b0;
               end
            endcase
         end
         // text ends inside the token: close it with this byte consumed
         if (reached && item.end_of_text) begin
            emit     = 1'b1;
            consumed = 1'b1;
            err      = !(phase_in inside {PH_INT, PH_ZERO, PH_FRAC, PH_EXPDIG});
         end
      end

      frac_wide = FW'(frac_in);
      frac_over = frac_wide > FW'({FO{1'b1}});
      exp_wide  = EW'(eacc_in);
      exp_over  = exp_wide > EW'({EO{1'b1}});

      result = '0;
      result.byte_consumed = consumed;
      if (err) begin
         result.status = jnp_pkg::STATUS_MISSING;
      end else begin
         result.is_integer        = intonly_in;
         result.negative          = sign_in;
         result.mantissa          = acc_in;
         result.fraction_digits   = frac_over ? {FO{1'b1}} : frac_wide[FO-1:0];
         result.exponent_negative = esign_in;
         result.exponent_value    = exp_over ? {EO{1'b1}} : exp_wide[EO-1:0];
         result.status            = (sat_in || frac_over || exp_over) ?
                                    jnp_pkg::STATUS_SATURATED : jnp_pkg::STATUS_OK;
      end

      // drop the token once its result goes out
      if (emit || (advance && cur == PH_IDLE && phase_in == PH_IDLE)) begin
         phase_in   = PH_IDLE;
         sign_in    = 1'b0;
         acc_in     = '0;
         intonly_in = 1'b1;
         frac_in    = '0;
         esign_in   = 1'b0;
         eacc_in    = '0;
         sat_in     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         sign_ff    <= 1'b0;
         acc_ff     <= '0;
         intonly_ff <= 1'b1;
         frac_ff    <= '0;
         esign_ff   <= 1'b0;
         eacc_ff    <= '0;
         sat_ff     <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         sign_ff    <= sign_in;
         acc_ff     <= acc_in;
         intonly_ff <= intonly_in;
         frac_ff    <= frac_in;
         esign_ff   <= esign_in;
         eacc_ff    <= eacc_in;
         sat_ff     <= sat_in;
      end
   end

   a_emit_needs_item: assert property (@(posedge clock) disable iff (reset)
      emit |-> advance)
      else $error("result produced without an item");

   a_emit_goes_idle: assert property (@(posedge clock) disable iff (reset)
      emit |=> (phase_ff == PH_IDLE) && (acc_ff == '0) && !sat_ff)
      else $error("token state not cleared after result");

   a_missing_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (emit && result.status == jnp_pkg::STATUS_MISSING) |->
         (result.mantissa == '0) && !result.is_integer && !result.negative)
      else $error("missing-digit result carries token fields");

   a_hold_without_item: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(phase_ff) && $stable(acc_ff) && $stable(eacc_ff))
      else $error("token state moved without an item");

endmodule

`default_nettype wire

FILE: design/jnp_out_stage.sv
// Result register that holds one token item until the consumer takes it.
`default_nettype none

module jnp_out_stage (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        load,
   input  wire jnp_pkg::rsp_item_type load_item,
   output logic                       can_take,
   output logic                       out_valid,
   output jnp_pkg::rsp_item_type      out_item,
   input  wire                        out_ready
);

   logic                  valid_ff, valid_in;
   jnp_pkg::rsp_item_type item_ff;

   assign can_take = !valid_ff || out_ready;
   assign valid_in = load || (valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         item_ff <= load_item;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load |-> (!valid_ff || out_ready))
      else $error("pending result overwritten");

endmodule

`default_nettype wire

FILE: design/json_number_token_parser.sv
// Top level of the JSON number token parser.
// Scans a JSON number one text byte per item and returns one token item when
// a byte ends the number or the text ends. A byte is taken every cycle when
// the result side keeps up; a byte goes from the input register through the
// scanner into the result register. The rate is set by the per-byte digit
// update: a times-ten shift-add on the 63-bit mantissa and the exponent,
// fed back into the token state. No result comes for bytes inside a number;
// a byte that ends the number without belonging to it is dropped
// (byte_consumed 0), so the next token must be flagged with starts_number.
`default_nettype none

module json_number_token_parser #(
   parameter int EXP_BITS        = 16,
   parameter int FRAC_COUNT_BITS = 8
) (
   input  wire        clock,
   input  wire        reset,
   jnp_req_if.sink    req_chan,
   jnp_rsp_if.source  rsp_chan
);

   jnp_pkg::req_item_type req_item;
   jnp_pkg::req_item_type held_item;
   jnp_pkg::rsp_item_type scan_result;
   jnp_pkg::rsp_item_type out_item;
   logic                  held_valid;
   logic                  out_free;
   logic                  advance;
   logic                  emit;
   logic                  out_valid;

   assign req_item.text_byte     = req_chan.text_byte;
   assign req_item.starts_number = req_chan.starts_number;
   assign req_item.end_of_text   = req_chan.end_of_text;

   // move the held byte through the scanner when the result slot is free
   assign advance = held_valid && out_free;

   jnp_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_chan.valid),
      .in_item    (req_item),
      .in_ready   (req_chan.ready),
      .advance    (advance),
      .held_valid (held_valid),
      .held_item  (held_item)
   );

   jnp_scanner #(
      .EXP_BITS        (EXP_BITS),
      .FRAC_COUNT_BITS (FRAC_COUNT_BITS)
   ) u_scan (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (held_item),
      .emit    (emit),
      .result  (scan_result)
   );

   jnp_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (emit),
      .load_item (scan_result),
      .can_take  (out_free),
      .out_valid (out_valid),
      .out_item  (out_item),
      .out_ready (rsp_chan.ready)
   );

   assign rsp_chan.valid             = out_valid;
   assign rsp_chan.is_integer        = out_item.is_integer;
   assign rsp_chan.negative          = out_item.negative;
   assign rsp_chan.mantissa          = out_item.mantissa;
   assign rsp_chan.fraction_digits   = out_item.fraction_digits;
   assign rsp_chan.exponent_negative = out_item.exponent_negative;
   assign rsp_chan.exponent_value    = out_item.exponent_value;
   assign rsp_chan.status            = out_item.status;
   assign rsp_chan.byte_consumed     = out_item.byte_consumed;

endmodule

`default_nettype wire

FILE: dv/tb_json_number_token_parser.sv
// Self-checking testbench for the JSON number token parser, with a scoreboard class.
`timescale 1ns / 100ps

module tb_json_number_token_parser;

   localparam int EXP_BITS        = 16;
   localparam int FRAC_COUNT_BITS = 8;
   localparam int BYTE_TARGET     = 1850;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int DRAIN_CYCLES    = 8;
   localparam int IDLE_PERCENT    = 23;

   localparam logic [63:0] MANT_LIMIT     = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] FRAC_LIMIT     = (64'd1 << FRAC_COUNT_BITS) - 64'd1;
   localparam logic [63:0] EXP_LIMIT      = (64'd1 << EXP_BITS) - 64'd1;
   localparam logic [63:0] FRAC_OUT_LIMIT = (64'd1 << jnp_pkg::FRAC_OUT_BITS) - 64'd1;
   localparam logic [63:0] EXP_OUT_LIMIT  = (64'd1 << jnp_pkg::EXP_OUT_BITS) - 64'd1;

   typedef enum logic [3:0] {
      SCAN_IDLE, SCAN_SIGN, SCAN_INT, SCAN_ZERO, SCAN_DOT,
      SCAN_FRAC, SCAN_EXP, SCAN_EXP_SIGN, SCAN_EXP_DIGITS
   } scan_phase_type;

   typedef logic [7:0] text_q_type[$];

   class token_checker;
      scan_phase_type        phase;
      bit                    minus_seen;
      bit                    whole_only;
      bit                    exp_minus;
      bit                    overflow;
      logic [63:0]           mant_acc;
      logic [63:0]           frac_count;
      logic [63:0]           exp_acc;
      jnp_pkg::rsp_item_type awaited_tokens[$];
      int                    fail_count;
      int                    tokens_checked;
      int                    saturated_seen;
      int                    missing_seen;

      function new();
         phase = SCAN_IDLE;
         clear_scan();
      endfunction

      function void clear_scan();
         minus_seen = 1'b0;
         whole_only = 1'b1;
         exp_minus  = 1'b0;
         overflow   = 1'b0;
         mant_acc   = '0;
         frac_count = '0;
         exp_acc    = '0;
      endfunction

      function logic [63:0] add_digit(logic [63:0] acc, logic [3:0] d, logic [63:0] limit);
         if (acc > (limit - 64'(d)) / 64'd10) begin
            overflow = 1'b1;
            return limit;
         end
         return acc * 64'd10 + 64'(d);
      endfunction

      function void close_token(bit missing, bit consumed);
         jnp_pkg::rsp_item_type tok;
         logic [63:0]           frac_out;
         logic [63:0]           exp_out;
         bit                    clamp;
         tok      = '0;
         clamp    = overflow;
         frac_out = frac_count;
         exp_out  = exp_acc;
         if (frac_out > FRAC_OUT_LIMIT) begin
            frac_out = FRAC_OUT_LIMIT;
            clamp    = 1'b1;
         end
         if (exp_out > EXP_OUT_LIMIT) begin
            exp_out = EXP_OUT_LIMIT;
            clamp   = 1'b1;
         end
         if (missing) begin
            tok.status = jnp_pkg::STATUS_MISSING;
         end else begin
            tok.is_integer        = whole_only;
            tok.negative          = minus_seen;
            tok.mantissa          = mant_acc[jnp_pkg::MANT_BITS-1:0];
            tok.fraction_digits   = frac_out[jnp_pkg::FRAC_OUT_BITS-1:0];
            tok.exponent_negative = exp_minus;
            tok.exponent_value    = exp_out[jnp_pkg::EXP_OUT_BITS-1:0];
            tok.status            = clamp ? jnp_pkg::STATUS_SATURATED : jnp_pkg::STATUS_OK;
         end
         tok.byte_consumed = consumed;
         awaited_tokens.push_back(tok);
         phase = SCAN_IDLE;
         clear_scan();
      endfunction

      function void close_if_last(bit last);
         bit complete;
         complete = (phase == SCAN_INT) || (phase == SCAN_ZERO) ||
                    (phase == SCAN_FRAC) || (phase == SCAN_EXP_DIGITS);
         if (last)
            close_token(!complete, 1'b1);
      endfunction

      // Advance the scan by one accepted byte; queue the token it ends, if any.
      function void note_byte(jnp_pkg::req_item_type it);
         logic [7:0] c;
         logic [3:0] d;
         bit         is_dig;
         bit         exp_mark;
         c        = it.text_byte;
         d        = 4'(c - jnp_pkg::CHAR_ZERO);
         is_dig   = (c >= jnp_pkg::CHAR_ZERO) && (c <= jnp_pkg::CHAR_NINE);
         exp_mark = (c == jnp_pkg::CHAR_EXP_LO) || (c == jnp_pkg::CHAR_EXP_UP);
         if (it.starts_number) begin
            clear_scan();
            phase = SCAN_SIGN;
            if (c == jnp_pkg::CHAR_MINUS) begin
               minus_seen = 1'b1;
               close_if_last(it.end_of_text);
               return;
            end
         end else if (phase == SCAN_IDLE) begin
            return;
         end
         case (phase)
            SCAN_SIGN: begin
               if (c == jnp_pkg::CHAR_ZERO) begin
                  phase = SCAN_ZERO;
               end else if (is_dig) begin
                  mant_acc = 64'(d);
                  phase    = SCAN_INT;
               end else begin
                  close_token(1'b1, 1'b0);
                  return;
               end
            end
            SCAN_INT, SCAN_ZERO: begin
               if (phase == SCAN_INT && is_dig) begin
                  mant_acc = add_digit(mant_acc, d, MANT_LIMIT);
               end else if (c == jnp_pkg::CHAR_DOT) begin
                  whole_only = 1'b0;
                  phase      = SCAN_DOT;
               end else if (exp_mark) begin
                  whole_only = 1'b0;
                  phase      = SCAN_EXP;
               end else begin
                  close_token(1'b0, 1'b0);
                  return;
               end
            end
            SCAN_DOT, SCAN_FRAC: begin
               if (is_dig) begin
                  mant_acc = add_digit(mant_acc, d, MANT_LIMIT);
                  if (frac_count >= FRAC_LIMIT)
                     overflow = 1'b1;
                  else
                     frac_count = frac_count + 64'd1;
                  phase = SCAN_FRAC;
               end else if (phase == SCAN_DOT) begin
                  close_token(1'b1, 1'b0);
                  return;
               end else if (exp_mark) begin
                  phase = SCAN_EXP;
               end else begin
                  close_token(1'b0, 1'b0);
                  return;
               end
            end
            SCAN_EXP, SCAN_EXP_SIGN, SCAN_EXP_DIGITS: begin
               if (phase == SCAN_EXP && c == jnp_pkg::CHAR_PLUS) begin
                  phase = SCAN_EXP_SIGN;
               end else if (phase == SCAN_EXP && c == jnp_pkg::CHAR_MINUS) begin
                  exp_minus = 1'b1;
                  phase     = SCAN_EXP_SIGN;
               end else if (is_dig) begin
                  exp_acc = add_digit(exp_acc, d, EXP_LIMIT);
                  phase   = SCAN_EXP_DIGITS;
               end else begin
                  close_token(phase != SCAN_EXP_DIGITS, 1'b0);
                  return;
               end
            end
            default: begin
               phase = SCAN_IDLE;
               clear_scan();
               return;
            end
         endcase
         close_if_last(it.end_of_text);
      endfunction

      function void compare_field(string name, logic [63:0] want, logic [63:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            fail_count++;
         end
      endfunction

      function void check_token(jnp_pkg::rsp_item_type got);
         jnp_pkg::rsp_item_type want;
         if (awaited_tokens.size() == 0) begin
            $display("%0t: token with none expected, expected nothing, got %p", $time, got);
            fail_count++;
            return;
         end
         want = awaited_tokens.pop_front();
         tokens_checked++;
         if (want.status == jnp_pkg::STATUS_SATURATED) saturated_seen++;
         if (want.status == jnp_pkg::STATUS_MISSING) missing_seen++;
         compare_field("is_integer", want.is_integer, got.is_integer);
         compare_field("negative", want.negative, got.negative);
         compare_field("mantissa", want.mantissa, got.mantissa);
         compare_field("fraction_digits", want.fraction_digits, got.fraction_digits);
         compare_field("exponent_negative", want.exponent_negative, got.exponent_negative);
         compare_field("exponent_value", want.exponent_value, got.exponent_value);
         compare_field("status", want.status, got.status);
         compare_field("byte_consumed", want.byte_consumed, got.byte_consumed);
      endfunction

      function void check_leftovers();
         while (awaited_tokens.size() != 0) begin
            $display("%0t: token never arrived, expected %p, got nothing", $time,
                     awaited_tokens.pop_front());
            fail_count++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   calm_window;
   int   token_bytes;
   int   cycle_count;

   token_checker board = new();

   jnp_req_if req_chan ();
   jnp_rsp_if rsp_chan ();

   json_number_token_parser #(
      .EXP_BITS        (EXP_BITS),
      .FRAC_COUNT_BITS (FRAC_COUNT_BITS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Run stopped after %0d cycles without draining", cycle_count);
      $display("** json_number_token_parser: FAILED **");
      $finish;
   end

   // Token side: random backpressure, check every accepted token.
   initial begin
      jnp_pkg::rsp_item_type got;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) begin
            got.is_integer        = rsp_chan.is_integer;
            got.negative          = rsp_chan.negative;
            got.mantissa          = rsp_chan.mantissa;
            got.fraction_digits   = rsp_chan.fraction_digits;
            got.exponent_negative = rsp_chan.exponent_negative;
            got.exponent_value    = rsp_chan.exponent_value;
            got.status            = rsp_chan.status;
            got.byte_consumed     = rsp_chan.byte_consumed;
            board.check_token(got);
         end
         rsp_chan.ready <= calm_window || ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   task automatic push_byte(logic [7:0] c, bit start, bit last);
      jnp_pkg::req_item_type it;
      it.text_byte     = c;
      it.starts_number = start;
      it.end_of_text   = last;
      while (!calm_window && $urandom_range(99) < IDLE_PERCENT) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid         <= 1'b1;
      req_chan.text_byte     <= c;
      req_chan.starts_number <= start;
      req_chan.end_of_text   <= last;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      board.note_byte(it);
   endtask

   task automatic send_chars(text_q_type q, bit last_ends_text);
      foreach (q[i])
         push_byte(q[i], i == 0, last_ends_text && (i == q.size() - 1));
      token_bytes += q.size();
   endtask

   task automatic send_text(string s, bit last_ends_text);
      text_q_type q;
      for (int i = 0; i < s.len(); i++)
         q.push_back(s[i]);
      send_chars(q, last_ends_text);
   endtask

   function automatic logic [7:0] any_digit(int lo);
      return jnp_pkg::CHAR_ZERO + 8'($urandom_range(9, lo));
   endfunction

   // Mostly well-formed numbers; a few long runs reach the saturation limits.
   function automatic text_q_type make_number();
      text_q_type q;
      int         n;
      if ($urandom_range(2) == 0) q.push_back(jnp_pkg::CHAR_MINUS);
      if ($urandom_range(5) == 0) begin
         q.push_back(jnp_pkg::CHAR_ZERO);
      end else begin
         q.push_back(any_digit(1));
         n = ($urandom_range(9) == 0) ? $urandom_range(21, 15) : $urandom_range(4);
         repeat (n) q.push_back(any_digit(0));
      end
      if ($urandom_range(1) == 0) begin
         q.push_back(jnp_pkg::CHAR_DOT);
         n = ($urandom_range(99) == 0) ? $urandom_range(262, 250) : $urandom_range(4, 1);
         repeat (n) q.push_back(any_digit(0));
      end
      if ($urandom_range(2) == 0) begin
         q.push_back($urandom_range(1) ? jnp_pkg::CHAR_EXP_LO : jnp_pkg::CHAR_EXP_UP);
         case ($urandom_range(2))
            0: q.push_back(jnp_pkg::CHAR_PLUS);
            1: q.push_back(jnp_pkg::CHAR_MINUS);
            default: ;
         endcase
         n = ($urandom_range(14) == 0) ? $urandom_range(7, 4) : $urandom_range(3, 1);
         repeat (n) q.push_back(any_digit(0));
      end
      // Break a few tokens: cut them short or overwrite one byte with a stray byte.
      if ($urandom_range(99) < 15) begin
         if ($urandom_range(1) == 0 && q.size() > 1)
            q = q[0:$urandom_range(q.size() - 2)];
         else
            q[$urandom_range(q.size() - 1)] = 8'($urandom_range(255));
      end
      return q;
   endfunction

   function automatic logic [7:0] delimiter();
      case ($urandom_range(4))
         0: return 8'h2C;
         1: return 8'h5D;
         2: return 8'h7D;
         3: return 8'h20;
         default: return 8'h0A;
      endcase
   endfunction

   initial begin
      reset                  <= 1'b1;
      req_chan.valid         <= 1'b0;
      req_chan.text_byte     <= '0;
      req_chan.starts_number <= 1'b0;
      req_chan.end_of_text   <= 1'b0;
      calm_window = 1'b0;
      token_bytes = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      send_text("0", 1'b1);
      send_text("-0", 1'b1);
      send_text("-12.5e+3", 1'b0);
      push_byte(8'h2C, 1'b0, 1'b0);
      send_text("1E-2", 1'b1);
      send_text("0.0", 1'b0);
      push_byte(8'h5D, 1'b0, 1'b0);
      send_text("01", 1'b1);
      send_text("-", 1'b0);
      push_byte(8'h78, 1'b0, 1'b0);
      send_text("1.", 1'b1);
      send_text("1e", 1'b0);
      push_byte(8'h20, 1'b0, 1'b0);
      send_text("1e+", 1'b1);
      // Drop an open token when a new one starts.
      send_text("25", 1'b0);
      send_text("3", 1'b1);
      push_byte(8'h61, 1'b0, 1'b0);
      push_byte(8'h00, 1'b0, 1'b1);
      send_text("9223372036854775807", 1'b1);
      send_text("9223372036854775808", 1'b1);
      send_text("1e65535", 1'b1);
      send_text("4e65536", 1'b1);
      send_text("3.14159e-10", 1'b0);
      push_byte(8'h7D, 1'b0, 1'b0);
      push_byte(8'hFF, 1'b1, 1'b0);

      while (token_bytes < BYTE_TARGET) begin
         calm_window = (token_bytes >= 700) && (token_bytes < 1000);
         if ($urandom_range(7) == 0) begin
            repeat ($urandom_range(3, 1))
               push_byte(8'($urandom_range(255)), $urandom_range(9) == 0,
                         $urandom_range(1));
         end
         case ($urandom_range(9))
            0, 1, 2: send_chars(make_number(), 1'b1);
            3, 4, 5, 6: begin
               send_chars(make_number(), 1'b0);
               push_byte(delimiter(), 1'b0, $urandom_range(3) == 0);
               token_bytes++;
            end
            7: begin
               send_chars(make_number(), 1'b0);
               push_byte(8'($urandom_range(255)), 1'b0, $urandom_range(1));
               token_bytes++;
            end
            default: send_chars(make_number(), 1'b0);
         endcase
      end
      calm_window = 1'b0;
      req_chan.valid <= 1'b0;

      while (board.awaited_tokens.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      board.check_leftovers();

      $display("Fed %0d number bytes plus stray bytes; checked %0d tokens", token_bytes,
               board.tokens_checked);
      $display("Tokens with saturation: %0d, with a missing digit: %0d",
               board.saturated_seen, board.missing_seen);
      if (board.fail_count == 0)
         $display("** json_number_token_parser: PASSED **");
      else
         $display("** json_number_token_parser: FAILED **");
      $finish;
   end

endmodule
